[hw/rtl/md5_message_digest_top_assert.svh]
// Assertion macros shared by the MD5 block's RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef MD5_MESSAGE_DIGEST_TOP_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_TOP_ASSERT_SVH

// Checks the consequent in the same cycle as the antecedent.
`define MD5MD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define MD5MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/md5md_pkg.sv]
// Package for the MD5 block: initial values, step constants and step functions.
// Used by md5md_engine and md5_message_digest_top; depends on nothing.
`timescale 1ns / 1ps

package md5md_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic start;
    logic reinit;
  } md5md_ctrl_t;

  typedef struct packed {
    logic busy;
  } md5md_stat_t;

  function automatic logic [3:0] md5_g(input logic [5:0] step);
    logic [3:0] s;
    logic [3:0] g;
    s = step[3:0];
    unique case (step[5:4])
      2'd0: g = s;
      2'd1: g = 4'(s + {s[1:0], 2'b00} + 4'd1);
      2'd2: g = 4'(s + {s[2:0], 1'b0} + 4'd5);
      default: g = 4'({s[0], 3'b000} - s);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_f(input logic [1:0] rnd, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (rnd)
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] w;
    w = {x, x} << r;
    return w[63:32];
  endfunction

endpackage

[hw/rtl/md5md_engine.sv]
// MD5 compression engine: one step per cycle over all 64 steps, plus the chaining words.
// Depends on md5md_pkg; reads the block buffer held in md5_message_digest_top.
`timescale 1ns / 1ps

module md5md_engine import md5md_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md5md_ctrl_t       ctrl_i,
  output md5md_stat_t       stat_o,
  output logic [3:0]        rd_idx_o,
  input  logic [31:0]       rd_word_i,
  output logic [3:0][31:0]  chain_o
);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_PREP = 2'd1;
  localparam logic [1:0] E_STEP = 2'd2;
  localparam logic [1:0] E_ACC  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [5:0]        step_q, step_d;
  logic [5:0]        step_nxt;
  logic [5:0]        fetch_step;
  logic [3:0][31:0]  chain_q, chain_d;
  logic [31:0]       a_q, b_q, c_q, d_q;
  logic [31:0]       km_q, km_d;
  logic [31:0]       sum_t;
  logic [31:0]       new_b;

  assign step_nxt   = step_q + 6'd1;
  assign fetch_step = (state_q == E_STEP) ? step_nxt : 6'd0;
  assign rd_idx_o   = md5_g(fetch_step);
  assign km_d       = rd_word_i + MD5_K[fetch_step];

  assign sum_t = a_q + md5_f(step_q[5:4], b_q, c_q, d_q) + km_q;
  assign new_b = b_q + md5_rotl(sum_t, MD5_ROT[{step_q[5:4], step_q[1:0]}]);

  assign stat_o.busy = (state_q != E_IDLE);
  assign chain_o     = chain_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    chain_d = chain_q;
    unique case (state_q)
      E_IDLE: begin
        if (ctrl_i.start) begin
          state_d = E_PREP;
        end
        if (ctrl_i.reinit) begin
          chain_d = {IV_D, IV_C, IV_B, IV_A};
        end
      end
      E_PREP: begin
        step_d  = 6'd0;
        state_d = E_STEP;
      end
      E_STEP: begin
        step_d = step_nxt;
        if (step_q == 6'd63) begin
          state_d = E_ACC;
        end
      end
      E_ACC: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        state_d    = E_IDLE;
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      step_q  <= 6'd0;
      chain_q <= {IV_D, IV_C, IV_B, IV_A};
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    km_q <= km_d;
    if (state_q == E_PREP) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (state_q == E_STEP) begin
      a_q <= d_q;
      b_q <= new_b;
      c_q <= b_q;
      d_q <= c_q;
    end
  end

endmodule

[hw/rtl/md5_message_digest_top.sv]
// MD5 message digest top level: word intake, block buffer, padding and digest output.
// Depends on md5md_pkg, md5md_engine and md5_message_digest_top_assert.svh.
//
// Usage: a message enters on the input channel as little-endian 32-bit words, one
// transaction per word, each with a byte count and an end-of-message flag. A word is
// taken when in_valid_i is high and in_stall_o is low. The block raises in_stall_o
// whenever it is busy padding, compressing or delivering a digest.
// A word that does not complete a 16-word block is simply stored. The sixteenth word
// starts a compression in the shared step unit, one MD5 step per cycle, and the block
// stalls through a load step, 64 MD5 steps, a feed-forward step and a hand-back step;
// no new word is taken until the compression is through.
// The final word adds one padding word per cycle up to the block end and one or two
// compressions, after which the digest leaves as four transactions a, b, c, d, one
// per cycle while the receiver does not stall, with final_word_o set on the fourth.
// When the receiver stalls, the digest word on the output holds until it is taken.
// Reset puts the chaining words at the MD5 initial values and empties the buffer;
// after the fourth digest word the block returns to that state for the next message.
`timescale 1ns / 1ps
`include "md5_message_digest_top_assert.svh"

module md5_message_digest_top import md5md_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        final_word_o
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_PAD  = 2'd1;
  localparam logic [1:0] T_WAIT = 2'd2;
  localparam logic [1:0] T_OUT  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [1:0]        ret_q, ret_d;
  logic [3:0]        fill_q, fill_d;
  logic [31:0]       len_q, len_d;
  logic [31:0]       pad_q, pad_d;
  logic              mark_q, mark_d;
  logic              lenw_q, lenw_d;
  logic [1:0]        idx_q, idx_d;
  logic [31:0]       buf_q [16];

  logic              in_acc;
  logic              out_acc;
  logic [2:0]        cnt_eff;
  logic [31:0]       pad_in;
  logic              push_en;
  logic [31:0]       push_word;
  logic              wrap;

  md5md_ctrl_t       eng_ctrl;
  md5md_stat_t       eng_stat;
  logic [3:0]        rd_idx;
  logic [31:0]       rd_word;
  logic [3:0][31:0]  chain;

  assign in_stall_o = (state_q != T_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o   = (state_q == T_OUT);
  assign out_acc       = out_valid_o && !out_stall_i;
  assign digest_word_o = chain[idx_q];
  assign word_index_o  = idx_q;
  assign final_word_o  = (idx_q == 2'd3);

  always_comb begin
    if (!end_of_message_i || byte_count_i > 3'd4) begin
      cnt_eff = 3'd4;
    end else begin
      cnt_eff = byte_count_i;
    end
  end

  always_comb begin
    unique case (cnt_eff)
      3'd3:    pad_in = {8'h80, data_word_i[23:0]};
      3'd2:    pad_in = {8'h00, 8'h80, data_word_i[15:0]};
      3'd1:    pad_in = {16'h0000, 8'h80, data_word_i[7:0]};
      default: pad_in = 32'h0000_0080;
    endcase
  end

  always_comb begin
    push_en   = 1'b0;
    push_word = data_word_i;
    if (state_q == T_IDLE) begin
      push_en = in_acc && (cnt_eff == 3'd4);
    end else if (state_q == T_PAD) begin
      push_en = 1'b1;
      if (mark_q) begin
        push_word = pad_q;
      end else if (fill_q == 4'd14) begin
        push_word = {len_q[28:0], 3'b000};
      end else begin
        push_word = 32'd0;
      end
    end
  end

  assign wrap            = push_en && (fill_q == 4'd15);
  assign eng_ctrl.start  = wrap;
  assign eng_ctrl.reinit = out_acc && (idx_q == 2'd3);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    fill_d  = push_en ? fill_q + 4'd1 : fill_q;
    len_d   = len_q;
    pad_d   = pad_q;
    mark_d  = mark_q;
    lenw_d  = lenw_q;
    idx_d   = idx_q;
    unique case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          len_d = len_q + {29'd0, cnt_eff};
          if (end_of_message_i) begin
            pad_d   = pad_in;
            mark_d  = 1'b1;
            lenw_d  = 1'b0;
            state_d = T_PAD;
          end
          if (wrap) begin
            ret_d   = end_of_message_i ? T_PAD : T_IDLE;
            state_d = T_WAIT;
          end
        end
      end
      T_PAD: begin
        if (mark_q) begin
          mark_d = 1'b0;
        end else if (fill_q == 4'd14) begin
          lenw_d = 1'b1;
        end
        if (wrap) begin
          ret_d   = lenw_q ? T_OUT : T_PAD;
          state_d = T_WAIT;
        end
      end
      T_WAIT: begin
        if (!eng_stat.busy) begin
          state_d = ret_q;
        end
      end
      T_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            len_d   = 32'd0;
            state_d = T_IDLE;
          end
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      ret_q   <= T_IDLE;
      fill_q  <= 4'd0;
      len_q   <= 32'd0;
      mark_q  <= 1'b0;
      lenw_q  <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      mark_q  <= mark_d;
      lenw_q  <= lenw_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q <= pad_d;
    if (push_en) begin
      buf_q[fill_q] <= push_word;
    end
  end

  assign rd_word = buf_q[rd_idx];

  md5md_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (eng_ctrl),
    .stat_o    (eng_stat),
    .rd_idx_o  (rd_idx),
    .rd_word_i (rd_word),
    .chain_o   (chain)
  );

  `MD5MD_ASSERT_SAME(a_start_idle, eng_ctrl.start, !eng_stat.busy, "Compression started while the engine was busy.")
  `MD5MD_ASSERT_NEXT(a_start_busy, eng_ctrl.start, eng_stat.busy && state_q == T_WAIT, "Engine did not take up a compression.")
  `MD5MD_ASSERT_SAME(a_out_empty, state_q == T_OUT, fill_q == 4'd0 && !mark_q, "Digest offered with a partly filled block.")
  `MD5MD_ASSERT_NEXT(a_out_last, out_acc && idx_q == 2'd3, state_q == T_IDLE && idx_q == 2'd0 && len_q == 32'd0, "Block not ready for a new message after the digest.")

endmodule
